[src/ihvs_pkg.sv]
// Shared constants, codes and helpers for the indexed heap victim selector.
package ihvs_pkg;

  localparam int ID_W          = 10;
  localparam int ID_SPACE      = 1 << ID_W;
  localparam int INV_W         = 16;
  localparam int TIME_W        = 64;
  localparam int SCORE_W       = 26;
  localparam int COUNT_W       = 11;
  localparam int LEVEL_W       = 3;
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_PRI_BITS  = 16;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [TIME_W-1:0]  NS_PER_SEC = 64'd1_000_000_000;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_CHANGE = 3'd1,
    FN_REMOVE = 3'd2,
    FN_POP    = 3'd3,
    FN_PEEK   = 3'd4,
    FN_COST   = 3'd5,
    FN_RANDOM = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_PRESENT  = 3'd4,
    ST_NO_CAND  = 3'd5
  } status_t;

  // whole seconds <= k  <=>  elapsed ns < (k+1) s
  function automatic logic [LEVEL_W-1:0] age_level(input logic [TIME_W-1:0] ns);
    logic [LEVEL_W-1:0] lvl;
    if (ns < 64'd11 * NS_PER_SEC) lvl = 3'd1;
    else if (ns < 64'd21 * NS_PER_SEC) lvl = 3'd2;
    else if (ns < 64'd46 * NS_PER_SEC) lvl = 3'd3;
    else if (ns < 64'd91 * NS_PER_SEC) lvl = 3'd4;
    else if (ns < 64'd181 * NS_PER_SEC) lvl = 3'd5;
    else if (ns < 64'd361 * NS_PER_SEC) lvl = 3'd6;
    else lvl = 3'd7;
    return lvl;
  endfunction

endpackage

[src/indexed_heap_victim_selector.sv]
// Indexed binary heap of entry ids with slot lookup and cost-benefit victim scan.
// One item at a time. After reset a clearing pass over all 1024 entry ids runs
// with in_ready low. Insert, change, remove and pop walk the heap; each level
// the entry moves takes a read of the heap memory, then a write back. Removing
// the entry in the last slot, or popping the only entry, needs no walk. Random
// select runs a bit-serial remainder unit. The cost-benefit scan visits every
// occupied slot and passes each entry with a non-zero invalid count through
// the same serial divider; entries with a zero count are skipped. A finished
// result sits in the output register while the next item is taken.
module indexed_heap_victim_selector #(
  parameter int CAPACITY      = ihvs_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = ihvs_pkg::DEF_PRI_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [9:0]  entry_id,
  input  logic [15:0] priority_req,
  input  logic [15:0] invalid_count,
  input  logic [63:0] entry_stamp,
  input  logic [63:0] now_ns,
  input  logic [31:0] random_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [9:0]  result_id,
  output logic [15:0] result_priority,
  output logic [25:0] cost_score,
  output logic [10:0] count
);

  localparam int PW     = PRIORITY_BITS;
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ID_W   = ihvs_pkg::ID_W;
  localparam int INV_W  = ihvs_pkg::INV_W;
  localparam int TIME_W = ihvs_pkg::TIME_W;
  localparam int PROD_W = INV_W + ihvs_pkg::LEVEL_W;
  localparam int DN     = (PW + 10 > 32) ? PW + 10 : 32;
  localparam int DD     = (SLOT_W > PROD_W) ? SLOT_W : PROD_W;
  localparam int IT_W   = $clog2(DN + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PW-1:0]     pri;
    logic [INV_W-1:0]  inv;
    logic [TIME_W-1:0] tm;
  } heap_rec_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } ent_rec_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_LOOK, S_HEAP, S_UP, S_UP_W, S_DN, S_DN_W,
    S_PLACE, S_DIV, S_RND, S_SC_RD, S_SC_AGE, S_SC_LVL, S_SC_CMP, S_SC_END, S_FIN
  } state_t;

  state_t state;

  // memories
  heap_rec_t heap_mem [0:CAPACITY];
  ent_rec_t  ent_mem  [0:ihvs_pkg::ID_SPACE-1];

  logic [SLOT_W-1:0] ha, hb, hw_addr;
  logic              hw_en;
  heap_rec_t         hw_data, ha_q, hb_q;
  logic [ID_W-1:0]   ea, ew_addr;
  logic              ew_en;
  ent_rec_t          ew_data, e_q;

  always_ff @(posedge clk) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    ha_q <= heap_mem[ha];
    hb_q <= heap_mem[hb];
  end

  always_ff @(posedge clk) begin
    if (ew_en) ent_mem[ew_addr] <= ew_data;
    e_q <= ent_mem[ea];
  end

  // control and working registers
  logic              order_mode;
  logic [SLOT_W-1:0] cnt, i;
  logic [ID_W-1:0]   clr_idx;
  heap_rec_t         cur;
  logic [2:0]        req_func;
  logic [ID_W-1:0]   req_id;
  logic [PW-1:0]     req_pri;
  logic [INV_W-1:0]  req_inv;
  logic [TIME_W-1:0] req_stamp, req_now;
  logic [31:0]       req_rnd;
  ihvs_pkg::status_t res_status;
  logic [ID_W-1:0]   res_id;
  logic [PW-1:0]     res_pri;
  logic [25:0]       res_score;
  logic [DN-1:0]     div_num, div_quo, best;
  logic [DD-1:0]     div_rem, div_den;
  logic [IT_W-1:0]   div_iter;
  logic              div_scan, found;
  logic [TIME_W-1:0] diff;
  logic [ID_W-1:0]   sc_id;
  logic [PW-1:0]     sc_pri;
  logic [INV_W-1:0]  sc_inv;

  function automatic logic below(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                 input logic mode);
    return mode ? (a < b) : (a > b);
  endfunction

  // child indices for sift down
  logic [SLOT_W:0] c_w, c1_w;
  logic            b_ok, pick_b, up_move, dn_move;
  heap_rec_t       ch;
  assign c_w    = {i, 1'b0};
  assign c1_w   = c_w + 1'b1;
  assign b_ok   = c1_w <= {1'b0, cnt};
  assign pick_b = b_ok && below(ha_q.pri, hb_q.pri, order_mode);
  assign ch     = pick_b ? hb_q : ha_q;
  assign dn_move = below(cur.pri, ch.pri, order_mode);
  assign up_move = below(ha_q.pri, cur.pri, order_mode);

  // serial divider step
  logic [DD:0]   div_t, div_sub;
  logic          div_ge;
  logic [PROD_W-1:0] den_prod;
  assign div_t   = {div_rem, div_num[DN-1]};
  assign div_ge  = div_t >= {1'b0, div_den};
  assign div_sub = div_t - {1'b0, div_den};
  assign den_prod = PROD_W'(sc_inv) * PROD_W'(ihvs_pkg::age_level(diff));

  logic ins_ok;
  assign ins_ok = !e_q.present && ({1'b0, cnt} < (SLOT_W + 1)'(CAPACITY));

  // operations that report empty on an empty queue
  logic needs_entry;
  assign needs_entry = (req_func == ihvs_pkg::FN_POP) || (req_func == ihvs_pkg::FN_PEEK) ||
                       (req_func == ihvs_pkg::FN_COST) || (req_func == ihvs_pkg::FN_RANDOM);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ha      = '0;
    hb      = '0;
    ea      = req_id;
    hw_en   = 1'b0;
    hw_addr = i;
    hw_data = cur;
    ew_en   = 1'b0;
    ew_addr = req_id;
    ew_data = '0;
    unique case (state)
      S_CLEAR: begin
        ew_en   = 1'b1;
        ew_addr = clr_idx;
      end
      S_DISPATCH: begin
        ha = SLOT_W'(1);
        hb = cnt;
      end
      S_LOOK: begin
        if (req_func == ihvs_pkg::FN_INSERT) begin
          if (ins_ok) begin
            ew_en   = 1'b1;
            ew_data = '{present: 1'b1, slot: SLOT_W'(cnt + 1'b1)};
          end
        end else begin
          ha = e_q.slot;
          hb = cnt;
        end
      end
      S_HEAP: begin
        if (req_func == ihvs_pkg::FN_REMOVE) begin
          ew_en = 1'b1;
        end else if (req_func == ihvs_pkg::FN_POP) begin
          ew_en   = 1'b1;
          ew_addr = ha_q.id;
        end
      end
      S_RND:   ha = SLOT_W'(div_rem + DD'(1));
      S_UP:    ha = i >> 1;
      S_UP_W: begin
        if (up_move) begin
          hw_en   = 1'b1;
          hw_data = ha_q;
          ew_en   = 1'b1;
          ew_addr = ha_q.id;
          ew_data = '{present: 1'b1, slot: i};
        end
      end
      S_DN: begin
        ha = c_w[SLOT_W-1:0];
        hb = b_ok ? c1_w[SLOT_W-1:0] : c_w[SLOT_W-1:0];
      end
      S_DN_W: begin
        if (dn_move) begin
          hw_en   = 1'b1;
          hw_data = ch;
          ew_en   = 1'b1;
          ew_addr = ch.id;
          ew_data = '{present: 1'b1, slot: i};
        end
      end
      S_PLACE: begin
        hw_en   = 1'b1;
        ew_en   = 1'b1;
        ew_addr = cur.id;
        ew_data = '{present: 1'b1, slot: i};
      end
      S_SC_RD: ha = i;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      cnt        <= '0;
      order_mode <= 1'b0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (cfg_we) order_mode <= cfg_wdata;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ID_W'(ihvs_pkg::ID_SPACE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_func  <= func;
            req_id    <= entry_id;
            req_pri   <= PW'(priority_req);
            req_inv   <= invalid_count;
            req_stamp <= entry_stamp;
            req_now   <= now_ns;
            req_rnd   <= random_value;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_id    <= '0;
          res_pri   <= '0;
          res_score <= '0;
          if (needs_entry && cnt == '0) res_status <= ihvs_pkg::ST_EMPTY;
          else res_status <= ihvs_pkg::ST_OK;
          unique case (req_func)
            ihvs_pkg::FN_INSERT, ihvs_pkg::FN_CHANGE, ihvs_pkg::FN_REMOVE:
              state <= S_LOOK;
            ihvs_pkg::FN_POP, ihvs_pkg::FN_PEEK: begin
              if (cnt == '0) begin
                state <= S_FIN;
              end else begin
                state <= S_HEAP;
              end
            end
            ihvs_pkg::FN_COST: begin
              if (cnt == '0) begin
                state <= S_FIN;
              end else begin
                i     <= SLOT_W'(1);
                found <= 1'b0;
                state <= S_SC_RD;
              end
            end
            ihvs_pkg::FN_RANDOM: begin
              if (cnt == '0) begin
                state <= S_FIN;
              end else begin
                div_num  <= DN'(req_rnd);
                div_den  <= DD'(cnt);
                div_rem  <= '0;
                div_iter <= IT_W'(DN);
                div_scan <= 1'b0;
                state    <= S_DIV;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_LOOK: begin
          if (req_func == ihvs_pkg::FN_INSERT) begin
            if (e_q.present) begin
              res_status <= ihvs_pkg::ST_PRESENT;
              state      <= S_FIN;
            end else if (!ins_ok) begin
              res_status <= ihvs_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              cur   <= '{id: req_id, pri: req_pri, inv: req_inv, tm: req_stamp};
              i     <= SLOT_W'(cnt + 1'b1);
              cnt   <= cnt + 1'b1;
              state <= S_UP;
            end
          end else if (!e_q.present) begin
            res_status <= ihvs_pkg::ST_ABSENT;
            state      <= S_FIN;
          end else begin
            i     <= e_q.slot;
            state <= S_HEAP;
          end
        end
        S_HEAP: begin
          priority case (req_func)
            ihvs_pkg::FN_CHANGE: begin
              cur <= '{id: ha_q.id, pri: req_pri, inv: req_inv, tm: ha_q.tm};
              state <= below(ha_q.pri, req_pri, order_mode) ? S_UP : S_DN;
            end
            ihvs_pkg::FN_REMOVE: begin
              cnt <= cnt - 1'b1;
              if (i < cnt) begin
                cur   <= hb_q;
                state <= below(ha_q.pri, hb_q.pri, order_mode) ? S_UP : S_DN;
              end else begin
                state <= S_FIN;
              end
            end
            ihvs_pkg::FN_POP: begin
              res_id  <= ha_q.id;
              res_pri <= ha_q.pri;
              cnt     <= cnt - 1'b1;
              if (cnt > SLOT_W'(1)) begin
                cur   <= hb_q;
                i     <= SLOT_W'(1);
                state <= S_DN;
              end else begin
                state <= S_FIN;
              end
            end
            default: begin
              // peek and random select
              res_id  <= ha_q.id;
              res_pri <= ha_q.pri;
              state   <= S_FIN;
            end
          endcase
        end
        S_UP: state <= (i > SLOT_W'(1)) ? S_UP_W : S_PLACE;
        S_UP_W: begin
          if (up_move) begin
            i     <= i >> 1;
            state <= S_UP;
          end else begin
            state <= S_PLACE;
          end
        end
        S_DN: state <= (c_w > {1'b0, cnt}) ? S_PLACE : S_DN_W;
        S_DN_W: begin
          if (dn_move) begin
            i     <= pick_b ? c1_w[SLOT_W-1:0] : c_w[SLOT_W-1:0];
            state <= S_DN;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: state <= S_FIN;
        S_DIV: begin
          div_rem  <= div_ge ? DD'(div_sub) : DD'(div_t);
          div_quo  <= {div_quo[DN-2:0], div_ge};
          div_num  <= div_num << 1;
          div_iter <= div_iter - 1'b1;
          if (div_iter == IT_W'(1)) state <= div_scan ? S_SC_CMP : S_RND;
        end
        S_RND: state <= S_HEAP;
        S_SC_RD: state <= S_SC_AGE;
        S_SC_AGE: begin
          if (ha_q.inv == '0) begin
            if (i == cnt) begin
              state <= S_SC_END;
            end else begin
              i     <= i + 1'b1;
              state <= S_SC_RD;
            end
          end else begin
            sc_id  <= ha_q.id;
            sc_pri <= ha_q.pri;
            sc_inv <= ha_q.inv;
            diff   <= req_now - ha_q.tm;
            state  <= S_SC_LVL;
          end
        end
        S_SC_LVL: begin
          div_den  <= DD'(den_prod);
          div_num  <= DN'({sc_pri, 10'b0});
          div_rem  <= '0;
          div_iter <= IT_W'(DN);
          div_scan <= 1'b1;
          state    <= S_DIV;
        end
        S_SC_CMP: begin
          // first smallest score wins
          if (!found || div_quo < best) begin
            found   <= 1'b1;
            best    <= div_quo;
            res_id  <= sc_id;
            res_pri <= sc_pri;
          end
          if (i == cnt) begin
            state <= S_SC_END;
          end else begin
            i     <= i + 1'b1;
            state <= S_SC_RD;
          end
        end
        S_SC_END: begin
          if (!found) begin
            res_status <= ihvs_pkg::ST_NO_CAND;
          end else begin
            res_score <= (best > DN'(ihvs_pkg::SCORE_MAX)) ? ihvs_pkg::SCORE_MAX
                                                           : 26'(best);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            status          <= res_status;
            result_id       <= res_id;
            result_priority <= 16'(res_pri);
            cost_score      <= res_score;
            count           <= 11'(cnt);
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cnt} <= (SLOT_W + 1)'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while busy");

  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP || state == S_DN || state == S_PLACE) |-> (i != '0))
    else $error("heap walk at slot zero");
`endif

endmodule

[bench/tb_indexed_heap_victim_selector.sv]
// Self-checking testbench for the indexed heap victim selector.
module tb_indexed_heap_victim_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int CAP = ihvs_pkg::DEF_CAPACITY;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [63:0] NS_SEC = 64'd1_000_000_000;

  typedef struct packed {
    ihvs_pkg::status_t st;
    logic [9:0]  id;
    logic [15:0] pri;
    logic [25:0] score;
    logic [10:0] cnt;
  } beat_t;

  logic clk = 1'b0, rst;
  logic cfg_we, cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] func;
  logic [9:0] entry_id;
  logic [15:0] priority_req, invalid_count;
  logic [63:0] entry_stamp, now_ns;
  logic [31:0] random_value;
  logic [2:0] status;
  logic [9:0] result_id;
  logic [15:0] result_priority;
  logic [25:0] cost_score;
  logic [10:0] count;

  indexed_heap_victim_selector dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .entry_id(entry_id),
    .priority_req(priority_req), .invalid_count(invalid_count),
    .entry_stamp(entry_stamp), .now_ns(now_ns), .random_value(random_value),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .result_id(result_id), .result_priority(result_priority),
    .cost_score(cost_score), .count(count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the queue
  logic [9:0]  heap_ids [1:CAP];
  logic [10:0] slot_of [0:1023];
  logic        is_queued [0:1023];
  logic [15:0] prio_of [0:1023];
  logic [15:0] inval_of [0:1023];
  logic [63:0] stamp_of [0:1023];
  int          occ;
  logic        largest_first;

  beat_t expected_beats[$];
  int    errors;
  int    idle_cycles;
  int    hold_long;
  bit    no_idle;
  logic [63:0] clock_ns;

  function automatic bit goes_below(logic [15:0] a, logic [15:0] b);
    return largest_first ? (a < b) : (a > b);
  endfunction

  function automatic void put(int s, logic [9:0] id);
    heap_ids[s] = id;
    slot_of[id] = s[10:0];
  endfunction

  function automatic void rise_to_root(int i);
    logic [9:0] id;
    id = heap_ids[i];
    while (i > 1 && goes_below(prio_of[heap_ids[i/2]], prio_of[id])) begin
      put(i, heap_ids[i/2]);
      i = i / 2;
    end
    put(i, id);
  endfunction

  function automatic void bubble_down(int i);
    logic [9:0] id;
    int c;
    id = heap_ids[i];
    forever begin
      c = 2 * i;
      if (c > occ) break;
      if (c + 1 <= occ && goes_below(prio_of[heap_ids[c]], prio_of[heap_ids[c+1]])) c++;
      if (!goes_below(prio_of[id], prio_of[heap_ids[c]])) break;
      put(i, heap_ids[c]);
      i = c;
    end
    put(i, id);
  endfunction

  function automatic logic [63:0] age_band(logic [63:0] secs);
    if (secs <= 10) return 1;
    if (secs <= 20) return 2;
    if (secs <= 45) return 3;
    if (secs <= 90) return 4;
    if (secs <= 180) return 5;
    if (secs <= 360) return 6;
    return 7;
  endfunction

  // applies one operation to the shadow and returns the beat it should give
  function automatic beat_t queue_op(logic [2:0] f, logic [9:0] id, logic [15:0] p,
                                     logic [15:0] iv, logic [63:0] stamp,
                                     logic [63:0] now, logic [31:0] rv);
    beat_t b;
    logic [15:0] old;
    logic [9:0] last;
    logic [63:0] sc, best;
    int pos;
    bit found;
    b = '0;
    b.st = ihvs_pkg::ST_OK;
    case (f)
      ihvs_pkg::FN_INSERT:
        if (is_queued[id]) b.st = ihvs_pkg::ST_PRESENT;
        else if (occ >= CAP) b.st = ihvs_pkg::ST_FULL;
        else begin
          is_queued[id] = 1'b1;
          prio_of[id] = p;
          inval_of[id] = iv;
          stamp_of[id] = stamp;
          occ++;
          put(occ, id);
          rise_to_root(occ);
        end
      ihvs_pkg::FN_CHANGE:
        if (!is_queued[id]) b.st = ihvs_pkg::ST_ABSENT;
        else begin
          old = prio_of[id];
          prio_of[id] = p;
          inval_of[id] = iv;
          if (goes_below(old, p)) rise_to_root(slot_of[id]);
          else bubble_down(slot_of[id]);
        end
      ihvs_pkg::FN_REMOVE:
        if (!is_queued[id]) b.st = ihvs_pkg::ST_ABSENT;
        else begin
          pos = slot_of[id];
          last = heap_ids[occ];
          is_queued[id] = 1'b0;
          occ--;
          if (pos <= occ) begin
            put(pos, last);
            if (goes_below(prio_of[id], prio_of[last])) rise_to_root(pos);
            else bubble_down(pos);
          end
        end
      ihvs_pkg::FN_POP, ihvs_pkg::FN_PEEK:
        if (occ == 0) b.st = ihvs_pkg::ST_EMPTY;
        else begin
          b.id = heap_ids[1];
          b.pri = prio_of[b.id];
          if (f == ihvs_pkg::FN_POP) begin
            is_queued[b.id] = 1'b0;
            put(1, heap_ids[occ]);
            occ--;
            if (occ > 0) bubble_down(1);
          end
        end
      ihvs_pkg::FN_COST:
        if (occ == 0) b.st = ihvs_pkg::ST_EMPTY;
        else begin
          found = 0;
          best = 0;
          for (int s = 1; s <= occ; s++) begin
            if (inval_of[heap_ids[s]] == 0) continue;
            sc = {38'd0, prio_of[heap_ids[s]], 10'd0} /
                 (64'(inval_of[heap_ids[s]]) *
                  age_band((now - stamp_of[heap_ids[s]]) / NS_SEC));
            if (!found || sc < best) begin
              found = 1;
              best = sc;
              b.id = heap_ids[s];
            end
          end
          if (!found) b.st = ihvs_pkg::ST_NO_CAND;
          else begin
            b.pri = prio_of[b.id];
            b.score = (best > 64'(ihvs_pkg::SCORE_MAX)) ? ihvs_pkg::SCORE_MAX : best[25:0];
          end
        end
      ihvs_pkg::FN_RANDOM:
        if (occ == 0) b.st = ihvs_pkg::ST_EMPTY;
        else begin
          b.id = heap_ids[rv % occ + 1];
          b.pri = prio_of[b.id];
        end
      default: ;
    endcase
    b.cnt = occ[10:0];
    return b;
  endfunction

  task automatic send(logic [2:0] f, logic [9:0] id, logic [15:0] p, logic [15:0] iv,
                      logic [63:0] stamp, logic [63:0] now, logic [31:0] rv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    entry_id <= id;
    priority_req <= p;
    invalid_count <= iv;
    entry_stamp <= stamp;
    now_ns <= now;
    random_value <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_beats.push_back(queue_op(f, id, p, iv, stamp, now, rv));
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(logic v);
    drain_wait();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    largest_first = v;
  endtask

  function automatic logic [9:0] queued_id();
    return (occ == 0) ? 10'($urandom) : heap_ids[$urandom_range(1, occ)];
  endfunction

  task automatic test_empty_queue();
    send(ihvs_pkg::FN_POP, 0, 0, 0, 0, 0, 0);
    send(ihvs_pkg::FN_PEEK, 0, 0, 0, 0, 0, 0);
    send(ihvs_pkg::FN_COST, 0, 0, 0, 0, '1, 0);
    send(ihvs_pkg::FN_RANDOM, 0, 0, 0, 0, 0, '1);
    send(ihvs_pkg::FN_REMOVE, 10'd1023, 0, 0, 0, 0, 0);
    send(ihvs_pkg::FN_CHANGE, 10'd0, 16'hffff, 16'hffff, 0, 0, 0);
    send(FN_UNUSED, '1, '1, '1, '1, '1, '1);
  endtask

  task automatic test_corner_cases();
    // zero invalid counts only: no candidate
    send(ihvs_pkg::FN_INSERT, 10'd0, 16'h0000, 16'h0000, 64'd0, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'd1023, 16'hffff, 16'h0000, '1, 0, 0);
    send(ihvs_pkg::FN_COST, 0, 0, 0, 0, 64'd5, 0);
    send(ihvs_pkg::FN_INSERT, 10'd0, 16'h1234, 16'h1, 0, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'h155, 16'h8000, 16'hffff, 64'd100, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'h2aa, 16'h0001, 16'h0001, 64'd400_000_000_000, 0, 0);
    send(ihvs_pkg::FN_PEEK, 0, 0, 0, 0, 0, 0);
    // stamp ahead of now wraps to the oldest band
    send(ihvs_pkg::FN_COST, 0, 0, 0, 0, 64'd50_000_000_000, 0);
    send(ihvs_pkg::FN_CHANGE, 10'd1023, 16'h0000, 16'hffff, 0, 0, 0);
    send(ihvs_pkg::FN_COST, 0, 0, 0, 0, '1, 0);
    send(ihvs_pkg::FN_CHANGE, 10'h155, 16'h0000, 16'h0001, 0, 0, 0);
    send(ihvs_pkg::FN_RANDOM, 0, 0, 0, 0, 0, 32'hffff_ffff);
    send(ihvs_pkg::FN_RANDOM, 0, 0, 0, 0, 0, 32'h0);
    send(ihvs_pkg::FN_REMOVE, 10'h2aa, 0, 0, 0, 0, 0);
    send(ihvs_pkg::FN_REMOVE, 10'h2aa, 0, 0, 0, 0, 0);
    while (occ > 0) send(ihvs_pkg::FN_POP, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_full_queue();
    int order[1024];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    no_idle = 1;
    foreach (order[i])
      send(ihvs_pkg::FN_INSERT, order[i][9:0], 16'($urandom_range(0, 300)), 16'($urandom),
           {$urandom, $urandom}, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'd7, 16'd1, 16'd1, 0, 0, 0);
    drain_wait();
    is_queued[7] = 1'b1;
    // full needs an unqueued id, but all ids are queued: free one, refill, insert it again
    send(ihvs_pkg::FN_REMOVE, 10'd7, 0, 0, 0, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'd7, 16'd9, 16'd9, 0, 0, 0);
    send(ihvs_pkg::FN_INSERT, 10'd7, 16'd9, 16'd9, 0, 0, 0);
    send(ihvs_pkg::FN_COST, 0, 0, 0, 0, {$urandom, $urandom}, 0);
    send(ihvs_pkg::FN_RANDOM, 0, 0, 0, 0, 0, $urandom);
    no_idle = 0;
  endtask

  task automatic test_random_ops(int n, int max_fill);
    int pick;
    logic [63:0] st;
    logic [15:0] p;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      clock_ns += 64'($urandom_range(0, 2_000_000)) * 64'd1000;
      case ($urandom_range(0, 3))
        0: st = {$urandom, $urandom};
        default: st = clock_ns - 64'($urandom_range(0, 400)) * NS_SEC
                      - 64'($urandom_range(0, 999_999_999));
      endcase
      p = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (occ >= max_fill && pick < 40) pick += 40;
      if (pick < 35)
        send(ihvs_pkg::FN_INSERT,
             ($urandom_range(0, 9) == 0) ? queued_id() : 10'($urandom),
             p, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom), st, 0, 0);
      else if (pick < 50)
        send(ihvs_pkg::FN_CHANGE,
             ($urandom_range(0, 9) == 0) ? 10'($urandom) : queued_id(),
             p, 16'($urandom_range(0, 3) == 0 ? 0 : $urandom), 0, 0, 0);
      else if (pick < 65)
        send(ihvs_pkg::FN_REMOVE,
             ($urandom_range(0, 9) == 0) ? 10'($urandom) : queued_id(),
             0, 0, 0, 0, 0);
      else if (pick < 78) send(ihvs_pkg::FN_POP, 0, 0, 0, 0, 0, 0);
      else if (pick < 86) send(ihvs_pkg::FN_PEEK, 0, 0, 0, 0, 0, 0);
      else if (pick < 93) send(ihvs_pkg::FN_COST, 0, 0, 0, 0, clock_ns, 0);
      else if (pick < 99) send(ihvs_pkg::FN_RANDOM, 0, 0, 0, 0, 0, $urandom);
      else send(FN_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0);
    end
  endtask

  task automatic test_output_stall();
    hold_long = 400;
    test_random_ops(40, 30);
  endtask

  // result side: random stalls, long hold when asked
  int stall_left;
  always @(posedge clk) begin
    beat_t exp_b;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (status !== exp_b.st) begin
            $error("status: expected %0d, got %0d", exp_b.st, status); errors++;
          end
          if (result_id !== exp_b.id) begin
            $error("result_id: expected %0d, got %0d", exp_b.id, result_id); errors++;
          end
          if (result_priority !== exp_b.pri) begin
            $error("result_priority: expected %0d, got %0d", exp_b.pri, result_priority);
            errors++;
          end
          if (cost_score !== exp_b.score) begin
            $error("cost_score: expected %0d, got %0d", exp_b.score, cost_score); errors++;
          end
          if (count !== exp_b.cnt) begin
            $error("count: expected %0d, got %0d", exp_b.cnt, count); errors++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (hold_long > 0) begin
        hold_long--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    func <= ihvs_pkg::FN_INSERT;
    entry_id <= '0;
    priority_req <= '0;
    invalid_count <= '0;
    entry_stamp <= '0;
    now_ns <= '0;
    random_value <= '0;
    errors = 0;
    hold_long = 0;
    no_idle = 0;
    occ = 0;
    largest_first = 1'b0;
    clock_ns = 64'd1_000_000_000_000;
    foreach (is_queued[i]) is_queued[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_corner_cases();
    set_order(1'b1);
    test_corner_cases();
    test_random_ops(250, 48);
    test_output_stall();
    set_order(1'b0);
    test_random_ops(250, 48);
    while (occ > 0) send(ihvs_pkg::FN_POP, 0, 0, 0, 0, 0, 0);
    test_full_queue();
    set_order(1'b1);
    test_random_ops(150, 24);

    drain_wait();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[indexed_heap_victim_selector.f]
src/ihvs_pkg.sv
src/indexed_heap_victim_selector.sv
bench/tb_indexed_heap_victim_selector.sv
